### design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Next-cycle implication, off while reset is high.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer bank assertion failed");

// Next-cycle implication that is checked during reset too.
`define ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("timer bank assertion failed");

`endif

### design/ttb_pkg.sv
`default_nettype none

package ttb_pkg;

  localparam int TIMER_COUNT = 16;
  localparam int IDX_W       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

  localparam int OP_W      = 3;
  localparam int ID_W      = 4;
  localparam int TMO_W     = 16;
  localparam int ST_W      = 2;
  localparam int COUNT_W   = 23;
  localparam int WIN_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int SCALE_W   = 7;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_START  = 3'd1,
    OP_STOP   = 3'd2,
    OP_PAUSE  = 3'd3,
    OP_RESUME = 3'd4,
    OP_QUERY  = 3'd5
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_STOPPED = 2'd0,
    ST_RUNNING = 2'd1,
    ST_PAUSED  = 2'd2,
    ST_TIMEOUT = 2'd3
  } st_t;

  localparam logic [CFG_IDX_W-1:0] CFG_W10_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_W10_END    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_W100_START = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_W100_END   = 2'd3;

  typedef struct packed {
    st_t                status;
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] limit;
  } entry_t;

  typedef struct packed {
    logic               start;
    logic [COUNT_W-1:0] dividend;
    logic [SCALE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [COUNT_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

### design/ttb_cmd_if.sv
`default_nettype none

interface ttb_cmd_if import ttb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [ID_W-1:0]  timer_id;
  logic [TMO_W-1:0] duration;

  modport source (output valid, output operation, output timer_id, output duration,
                  input ready);
  modport sink   (input valid, input operation, input timer_id, input duration,
                  output ready);
endinterface

`default_nettype wire

### design/ttb_rsp_if.sv
`default_nettype none

interface ttb_rsp_if import ttb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ST_W-1:0]    status;
  logic [COUNT_W-1:0] elapsed;

  modport source (output valid, output status, output elapsed, input ready);
  modport sink   (input valid, input status, input elapsed, output ready);
endinterface

`default_nettype wire

### design/ttb_cfg_if.sv
`default_nettype none

interface ttb_cfg_if import ttb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WIN_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### design/ttb_ram.sv
`default_nettype none

module ttb_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire logic [WIDTH-1:0]     wr_data,
  input  wire logic [AW-1:0]        rd_addr,
  output      logic [WIDTH-1:0]     rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

`default_nettype wire

### design/ttb_div.sv
`default_nettype none

module ttb_div import ttb_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output      div_rsp_t rsp
);
  localparam int MUL_W  = 24;
  localparam int PROD_W = COUNT_W + MUL_W;
  localparam logic [MUL_W-1:0] MUL10  = MUL_W'(13421773);
  localparam logic [MUL_W-1:0] MUL100 = MUL_W'(10737419);
  localparam int SH10  = 27;
  localparam int SH100 = 30;

  logic               done;
  logic [SCALE_W-1:0] divisor;
  logic [PROD_W-1:0]  prod;
  logic [MUL_W-1:0]   mul;
  logic [COUNT_W-1:0] quo;

  // reciprocal multiply, exact for any 23-bit dividend
  always_comb begin
    case (req.divisor)
      SCALE_W'(10):  mul = MUL10;
      SCALE_W'(100): mul = MUL100;
      default:       mul = MUL_W'(1);
    endcase
  end

  always_comb begin
    case (divisor)
      SCALE_W'(10):  quo = COUNT_W'(prod >> SH10);
      SCALE_W'(100): quo = COUNT_W'(prod >> SH100);
      default:       quo = COUNT_W'(prod);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req.start;
      if (req.start) begin
        divisor <= req.divisor;
        prod    <= PROD_W'(req.dividend) * PROD_W'(mul);
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;
endmodule

`default_nettype wire

### design/timeout_timer_bank.sv
// Timeout timer bank: TIMER_COUNT timers sharing a common tick.
// Channels: cmd (operation, timer_id, duration), rsp (status, elapsed) and a
// cfg write port that sets the 10x and 100x id windows; cfg is always ready.
// Only a query request produces a response; all other operations are silent.
// Timer state lives in one single-port-write RAM, one entry per timer.
// Tick: the sequencer walks the RAM one timer per cycle, and cmd is not ready
// until the walk has passed the last timer.
// Start, stop, pause, resume: one read-modify-write in S_CMD, after which cmd
// is ready again.
// Query: the count is divided by the scale with a registered reciprocal
// multiply; the request passes S_CMD, S_DIV and S_OUT, and the response is
// valid in the same cycle that cmd is ready again.
// Responses sit in an output register; a new request is taken while one waits.
// If rsp stalls, a following query holds in its last step until rsp frees up.
// Reset: windows go to zero, then a clearing pass writes every RAM entry to
// stopped/zero with cmd not ready.
`default_nettype none

module timeout_timer_bank import ttb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  ttb_cmd_if.sink   cmd,
  ttb_rsp_if.source rsp,
  ttb_cfg_if.sink   cfg
);
  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_TICK, S_CMD, S_DIV, S_OUT} state_t;
  typedef enum logic [1:0] {SCALE_1, SCALE_10, SCALE_100} scale_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_COUNT - 1);

  state_t             state;
  logic [IDX_W-1:0]   idx;
  op_t                op_q;
  logic [ID_W-1:0]    id_q;
  logic [IDX_W-1:0]   addr_q;
  logic               id_ok_q;
  logic [TMO_W-1:0]   tmo_q;
  st_t                res_status;
  logic               rsp_valid;
  st_t                rsp_status;
  logic [COUNT_W-1:0] rsp_elapsed;

  logic [WIN_W-1:0]   w10_start;
  logic [WIN_W-1:0]   w10_end;
  logic [WIN_W-1:0]   w100_start;
  logic [WIN_W-1:0]   w100_end;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;
  logic [IDX_W-1:0]   rd_addr;
  entry_t             rd_entry;
  entry_t             tick_entry;
  entry_t             cmd_entry;
  logic [COUNT_W-1:0] cnt_inc;
  logic [COUNT_W-1:0] tmo_ext;
  logic [COUNT_W-1:0] tmo_scaled;
  scale_t             scale;
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic               cmd_fire;
  logic               out_free;

  function automatic logic [IDX_W-1:0] to_addr(input logic [ID_W-1:0] id);
    logic [31:0] w;
    w = 32'(id);
    return w[IDX_W-1:0];
  endfunction

  function automatic scale_t scale_of(input logic [ID_W-1:0] id,
                                      input logic [WIN_W-1:0] s10,
                                      input logic [WIN_W-1:0] e10,
                                      input logic [WIN_W-1:0] s100,
                                      input logic [WIN_W-1:0] e100);
    logic [WIN_W-1:0] x;
    x = WIN_W'(id);
    if (s10 < x && x < e10) begin
      return SCALE_10;
    end else if (s100 < x && x < e100) begin
      return SCALE_100;
    end
    return SCALE_1;
  endfunction

  assign cmd.ready = (state == S_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign out_free  = !rsp_valid || rsp.ready;
  assign cfg.ready = 1'b1;

  assign rsp.valid   = rsp_valid;
  assign rsp.status  = rsp_status;
  assign rsp.elapsed = rsp_elapsed;

  always_ff @(posedge clk) begin
    if (rst) begin
      w10_start  <= '0;
      w10_end    <= '0;
      w100_start <= '0;
      w100_end   <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_W10_START:  w10_start  <= cfg.data;
        CFG_W10_END:    w10_end    <= cfg.data;
        CFG_W100_START: w100_start <= cfg.data;
        CFG_W100_END:   w100_end   <= cfg.data;
        default: ;
      endcase
    end
  end

  ttb_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TIMER_COUNT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  ttb_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    scale   = scale_of(id_q, w10_start, w10_end, w100_start, w100_end);
    tmo_ext = COUNT_W'(tmo_q);
    case (scale)
      SCALE_10:  tmo_scaled = (tmo_ext << 3) + (tmo_ext << 1);
      SCALE_100: tmo_scaled = (tmo_ext << 6) + (tmo_ext << 5) + (tmo_ext << 2);
      default:   tmo_scaled = tmo_ext;
    endcase
  end

  always_comb begin
    tick_entry = rd_entry;
    cnt_inc    = rd_entry.count + COUNT_W'(1);
    if (rd_entry.status == ST_RUNNING) begin
      tick_entry.count = cnt_inc;
      if (rd_entry.limit <= cnt_inc) begin
        tick_entry.status = ST_TIMEOUT;
      end
    end
  end

  always_comb begin
    cmd_entry = rd_entry;
    case (op_q)
      OP_START: begin
        cmd_entry.status = ST_RUNNING;
        cmd_entry.count  = '0;
        cmd_entry.limit  = tmo_scaled;
      end
      OP_STOP: begin
        cmd_entry.status = ST_STOPPED;
        cmd_entry.count  = '0;
      end
      OP_PAUSE:  cmd_entry.status = ST_PAUSED;
      OP_RESUME: begin
        if (rd_entry.status == ST_PAUSED) begin
          cmd_entry.status = ST_RUNNING;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    wr_en            = 1'b0;
    wr_addr          = idx;
    wr_data          = cmd_entry;
    rd_addr          = idx;
    div_req.start    = 1'b0;
    div_req.dividend = id_ok_q ? rd_entry.count : '0;
    case (scale)
      SCALE_10:  div_req.divisor = SCALE_W'(10);
      SCALE_100: div_req.divisor = SCALE_W'(100);
      default:   div_req.divisor = SCALE_W'(1);
    endcase
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '0;
      end
      S_IDLE: rd_addr = (op_t'(cmd.operation) == OP_TICK) ? '0 : to_addr(cmd.timer_id);
      S_TICK: begin
        rd_addr = (idx == LAST_IDX) ? idx : idx + IDX_W'(1);
        wr_en   = 1'b1;
        wr_data = tick_entry;
      end
      S_CMD: begin
        rd_addr       = addr_q;
        wr_addr       = addr_q;
        wr_en         = id_ok_q && (op_q == OP_START || op_q == OP_STOP ||
                                    op_q == OP_PAUSE || op_q == OP_RESUME);
        div_req.start = (op_q == OP_QUERY);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      idx       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (idx == LAST_IDX) begin
            state <= S_IDLE;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_IDLE: begin
          if (cmd_fire) begin
            op_q    <= op_t'(cmd.operation);
            id_q    <= cmd.timer_id;
            addr_q  <= to_addr(cmd.timer_id);
            id_ok_q <= 32'(cmd.timer_id) < TIMER_COUNT;
            tmo_q   <= cmd.duration;
            idx     <= '0;
            state   <= (op_t'(cmd.operation) == OP_TICK) ? S_TICK : S_CMD;
          end
        end
        S_TICK: begin
          if (idx == LAST_IDX) begin
            state <= S_IDLE;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_CMD: begin
          res_status <= id_ok_q ? rd_entry.status : ST_STOPPED;
          state      <= (op_q == OP_QUERY) ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            rsp_status  <= res_status;
            rsp_elapsed <= div_rsp.quotient;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

`default_nettype wire

### design/ttb_checker.sv
`default_nettype none
`include "assert_macros.svh"

module ttb_checker import ttb_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               cmd_valid,
  input wire logic               cmd_ready,
  input wire logic [OP_W-1:0]    cmd_operation,
  input wire logic               rsp_valid,
  input wire logic               rsp_ready,
  input wire logic [ST_W-1:0]    rsp_status,
  input wire logic [COUNT_W-1:0] rsp_elapsed
);
  // stalled response holds
  `ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_elapsed))
  // clearing pass follows reset, nothing pending
  `ASSERT_NEXT_ALWAYS(a_reset_busy, rst, !cmd_ready && !rsp_valid)
  // cmd drops ready after every accepted request
  `ASSERT_NEXT(a_busy_after_req, cmd_valid && cmd_ready, !cmd_ready)
  // only queries respond
  `ASSERT_NEXT(a_silent_ops, cmd_valid && cmd_ready && cmd_operation != OP_QUERY && !rsp_valid, !rsp_valid)
endmodule

bind timeout_timer_bank ttb_checker u_ttb_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .cmd_operation (cmd.operation),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_status    (rsp.status),
  .rsp_elapsed   (rsp.elapsed)
);

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import ttb_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    st_t                status;
    logic [COUNT_W-1:0] elapsed;
  } query_rsp_t;

  logic clk;
  logic rst;

  ttb_cmd_if cmd_bus ();
  ttb_rsp_if rsp_bus ();
  ttb_cfg_if cfg_bus ();

  timeout_timer_bank dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_bus),
    .rsp(rsp_bus),
    .cfg(cfg_bus)
  );

  // timer bank shadow
  st_t                tmr_status [TIMER_COUNT];
  logic [COUNT_W-1:0] tmr_count  [TIMER_COUNT];
  logic [COUNT_W-1:0] tmr_limit  [TIMER_COUNT];
  logic [WIN_W-1:0]   win10_lo, win10_hi, win100_lo, win100_hi;

  query_rsp_t pending_queries[$];
  int         errors;
  int         rsp_hold_cycles;
  bit         calm;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int unsigned id_scale(int unsigned id);
    if (win10_lo < id && id < win10_hi) return 10;
    if (win100_lo < id && id < win100_hi) return 100;
    return 1;
  endfunction

  function automatic void clear_bank();
    for (int t = 0; t < TIMER_COUNT; t++) begin
      tmr_status[t] = ST_STOPPED;
      tmr_count[t]  = '0;
      tmr_limit[t]  = '0;
    end
    win10_lo  = '0;
    win10_hi  = '0;
    win100_lo = '0;
    win100_hi = '0;
  endfunction

  function automatic void apply_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                        logic [TMO_W-1:0] tmo);
    query_rsp_t q;
    case (op)
      OP_TICK: begin
        for (int t = 0; t < TIMER_COUNT; t++) begin
          if (tmr_status[t] == ST_RUNNING) begin
            tmr_count[t] = tmr_count[t] + 1'b1;
            if (tmr_limit[t] <= tmr_count[t]) tmr_status[t] = ST_TIMEOUT;
          end
        end
      end
      OP_START: begin
        tmr_status[id] = ST_RUNNING;
        tmr_count[id]  = '0;
        tmr_limit[id]  = COUNT_W'(32'(tmo) * id_scale(id));
      end
      OP_STOP: begin
        tmr_status[id] = ST_STOPPED;
        tmr_count[id]  = '0;
      end
      OP_PAUSE: tmr_status[id] = ST_PAUSED;
      OP_RESUME: begin
        if (tmr_status[id] == ST_PAUSED) tmr_status[id] = ST_RUNNING;
      end
      OP_QUERY: begin
        q.status  = tmr_status[id];
        q.elapsed = COUNT_W'(32'(tmr_count[id]) / id_scale(id));
        pending_queries.push_back(q);
      end
      default: ;
    endcase
  endfunction

  // leaves valid high on return; callers drop it via settle()
  task automatic issue_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                               logic [TMO_W-1:0] tmo);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.valid     <= 1'b1;
    cmd_bus.operation <= op;
    cmd_bus.timer_id  <= id;
    cmd_bus.duration  <= tmo;
    do @(posedge clk); while (!cmd_bus.ready);
    apply_request(op, id, tmo);
  endtask

  task automatic settle();
    cmd_bus.valid <= 1'b0;
    while (pending_queries.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_windows(logic [WIN_W-1:0] lo10, logic [WIN_W-1:0] hi10,
                             logic [WIN_W-1:0] lo100, logic [WIN_W-1:0] hi100);
    logic [CFG_IDX_W-1:0] regs[4];
    logic [WIN_W-1:0]     vals[4];
    regs = '{CFG_W10_START, CFG_W10_END, CFG_W100_START, CFG_W100_END};
    vals = '{lo10, hi10, lo100, hi100};
    for (int i = 0; i < 4; i++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= regs[i];
      cfg_bus.data  <= vals[i];
      do @(posedge clk); while (!cfg_bus.ready);
      case (regs[i])
        CFG_W10_START:  win10_lo  = vals[i];
        CFG_W10_END:    win10_hi  = vals[i];
        CFG_W100_START: win100_lo = vals[i];
        CFG_W100_END:   win100_hi = vals[i];
        default: ;
      endcase
    end
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic test_basic_ops();
    issue_request(OP_QUERY, 4'd0, 16'h0000);
    issue_request(OP_QUERY, 4'd15, 16'hFFFF);
    issue_request(OP_START, 4'd3, 16'h0000);
    issue_request(OP_TICK, 4'd9, 16'h1234);
    issue_request(OP_QUERY, 4'd3, 16'h0000);
    issue_request(OP_START, 4'd15, 16'hFFFF);
    issue_request(OP_START, 4'd0, 16'h0002);
    issue_request(OP_TICK, 4'd0, 16'h0000);
    issue_request(OP_PAUSE, 4'd0, 16'h0000);
    issue_request(OP_TICK, 4'd15, 16'hFFFF);
    issue_request(OP_QUERY, 4'd0, 16'h0000);
    issue_request(OP_RESUME, 4'd0, 16'h0000);
    issue_request(OP_TICK, 4'd0, 16'h0000);
    issue_request(OP_TICK, 4'd0, 16'h0000);
    issue_request(OP_QUERY, 4'd0, 16'h0000);
    issue_request(OP_RESUME, 4'd15, 16'h0000);
    issue_request(OP_PAUSE, 4'd7, 16'h0000);
    issue_request(OP_QUERY, 4'd7, 16'h0000);
    issue_request(OP_RESUME, 4'd7, 16'h0000);
    issue_request(OP_PAUSE, 4'd3, 16'h0000);
    issue_request(OP_STOP, 4'd15, 16'h0000);
    issue_request(OP_SPARE6, 4'd5, 16'hFFFF);
    issue_request(OP_SPARE7, 4'd15, 16'hFFFF);
    issue_request(OP_QUERY, 4'd15, 16'h0000);
    issue_request(OP_QUERY, 4'd7, 16'h0000);
    settle();
  endtask

  // window edges are exclusive; a query uses the windows in force at query time
  task automatic test_window_scaling();
    set_windows(5'd3, 5'd6, 5'd0, 5'd0);
    issue_request(OP_START, 4'd3, 16'h0001);
    issue_request(OP_START, 4'd4, 16'h0001);
    issue_request(OP_START, 4'd6, 16'h0001);
    issue_request(OP_START, 4'd5, 16'hFFFF);
    issue_request(OP_TICK, 4'd0, 16'h0000);
    issue_request(OP_TICK, 4'd0, 16'h0000);
    issue_request(OP_QUERY, 4'd4, 16'h0000);
    issue_request(OP_QUERY, 4'd6, 16'h0000);
    settle();
    set_windows(5'd0, 5'd0, 5'd3, 5'd16);
    issue_request(OP_START, 4'd14, 16'hFFFF);
    issue_request(OP_QUERY, 4'd5, 16'h0000);
    issue_request(OP_QUERY, 4'd14, 16'h0000);
    settle();
  endtask

  task automatic test_output_backpressure();
    rsp_hold_cycles = 400;
    for (int n = 0; n < 20; n++)
      issue_request(OP_QUERY, 4'($urandom_range(0, 15)), 16'($urandom));
    settle();
  endtask

  task automatic test_random_traffic(logic [WIN_W-1:0] lo10, logic [WIN_W-1:0] hi10,
                                     logic [WIN_W-1:0] lo100, logic [WIN_W-1:0] hi100,
                                     int n_items, bit quiet);
    int               r;
    logic [OP_W-1:0]  op;
    logic [TMO_W-1:0] tmo;
    set_windows(lo10, hi10, lo100, hi100);
    calm = quiet;
    for (int n = 0; n < n_items; n++) begin
      r = $urandom_range(0, 99);
      if (r < 38)      op = OP_TICK;
      else if (r < 55) op = OP_START;
      else if (r < 61) op = OP_STOP;
      else if (r < 68) op = OP_PAUSE;
      else if (r < 76) op = OP_RESUME;
      else if (r < 97) op = OP_QUERY;
      else             op = ($urandom_range(0, 1) == 0) ? OP_SPARE6 : OP_SPARE7;
      r = $urandom_range(0, 9);
      if (r < 7)      tmo = 16'($urandom_range(0, 4));
      else if (r < 9) tmo = 16'($urandom);
      else            tmo = '1;
      issue_request(op, 4'($urandom_range(0, 15)), tmo);
    end
    settle();
  endtask

  // response ready: random stalls, plus a long hold when requested
  initial begin
    int n;
    rsp_bus.ready <= 1'b0;
    forever begin
      if (rsp_hold_cycles > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (rsp_hold_cycles) @(posedge clk);
        rsp_hold_cycles = 0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        rsp_bus.ready <= 1'b0;
        n = $urandom_range(1, 18);
        repeat (n) @(posedge clk);
      end else begin
        rsp_bus.ready <= 1'b1;
        n = $urandom_range(1, 30);
        repeat (n) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    query_rsp_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_queries.size() == 0) begin
        errors++;
        $error("response with no query outstanding");
      end else begin
        want = pending_queries.pop_front();
        if (rsp_bus.status !== want.status) begin
          errors++;
          $error("status mismatch: expected %0d, got %0d", want.status, rsp_bus.status);
        end
        if (rsp_bus.elapsed !== want.elapsed) begin
          errors++;
          $error("elapsed mismatch: expected %0d, got %0d", want.elapsed, rsp_bus.elapsed);
        end
      end
    end
  end

  initial begin
    errors          = 0;
    rsp_hold_cycles = 0;
    calm            = 1'b0;
    clear_bank();
    rst               <= 1'b1;
    cmd_bus.valid     <= 1'b0;
    cmd_bus.operation <= OP_TICK;
    cmd_bus.timer_id  <= '0;
    cmd_bus.duration  <= '0;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.index     <= CFG_W10_START;
    cfg_bus.data      <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_basic_ops();
    test_window_scaling();
    test_output_backpressure();
    test_random_traffic(5'd0, 5'd0, 5'd0, 5'd0, 180, 1'b0);
    test_random_traffic(5'd0, 5'd16, 5'd0, 5'd16, 200, 1'b0);
    test_random_traffic(5'd16, 5'd0, 5'd0, 5'd16, 180, 1'b0);
    test_random_traffic(5'd2, 5'd9, 5'd5, 5'd16, 200, 1'b0);
    test_random_traffic(5'd4, 5'd12, 5'd16, 5'd16, 200, 1'b1);

    if (errors == 0 && pending_queries.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
